>>> sv/plg_pkg.sv
// Shared types, constants and band table functions of the pool level governor.
`default_nettype none
package plg_pkg;

  // Number of pool levels and widths of the level and dwell counters.
  localparam int unsigned NUM_LEVELS = 5;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned DWELL_W    = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_COUNT    = LEVEL_W'(NUM_LEVELS);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET    = 3'd4;
  localparam logic [DWELL_W-1:0] DWELL_MAX      = 7'd127;
  localparam logic [5:0]         NO_MATCH_SLEEP = 6'd5;
  localparam logic [15:0]        POOL_LIMIT_RST = 16'd1024;

  // Rate bands per level, each the half-open range [low, high).
  localparam logic signed [15:0] RATE_LOW [NUM_LEVELS] =
    '{-16'sd999, 16'sd2, 16'sd6, 16'sd10, 16'sd24};
  localparam logic signed [15:0] RATE_HIGH [NUM_LEVELS] =
    '{16'sd2, 16'sd6, 16'sd10, 16'sd24, 16'sd999};

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_RSVD   = 2'd3
  } plg_op_e;

  // Input item payload.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] rate;
    logic [15:0]        idle_count;
    logic [15:0]        total_count;
    logic [2:0]         lock_level;
  } plg_item_t;

  // Result item payload.
  typedef struct packed {
    logic [8:0]  alloc_count;
    logic [15:0] free_count;
    logic [5:0]  sleep_seconds;
    logic [2:0]  level;
    logic        no_match;
    logic        bad_level;
  } plg_result_t;

  // Governor state carried from item to item.
  typedef struct packed {
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] tgt;
    logic [DWELL_W-1:0] dwell;
    logic               locked;
  } plg_state_t;

  // Sampling time of a level; out-of-range levels read as the top level.
  function automatic logic [5:0] sample_time(input logic [LEVEL_W-1:0] lvl);
    logic [5:0] t;
    unique case (lvl)
      3'd0:    t = 6'd32;
      3'd1:    t = 6'd16;
      3'd2:    t = 6'd8;
      3'd3:    t = 6'd4;
      default: t = 6'd1;
    endcase
    return t;
  endfunction

  // Time a target level must hold before it becomes current.
  function automatic logic [5:0] valid_time(input logic [LEVEL_W-1:0] lvl);
    logic [5:0] t;
    unique case (lvl)
      3'd0:    t = 6'd32;
      3'd1:    t = 6'd16;
      3'd2:    t = 6'd8;
      3'd3:    t = 6'd4;
      default: t = 6'd2;
    endcase
    return t;
  endfunction

  // Low watermark of idle messages.
  function automatic logic [9:0] mark_low(input logic [LEVEL_W-1:0] lvl);
    logic [9:0] m;
    unique case (lvl)
      3'd0, 3'd1, 3'd2: m = 10'd64;
      default:          m = 10'd128;
    endcase
    return m;
  endfunction

  // High watermark of idle messages.
  function automatic logic [9:0] mark_high(input logic [LEVEL_W-1:0] lvl);
    logic [9:0] m;
    unique case (lvl)
      3'd0, 3'd1, 3'd2: m = 10'd128;
      3'd3:             m = 10'd256;
      default:          m = 10'd512;
    endcase
    return m;
  endfunction

  // Number of messages added per tick when idle runs low.
  function automatic logic [8:0] inc_size(input logic [LEVEL_W-1:0] lvl);
    logic [8:0] s;
    unique case (lvl)
      3'd0:    s = 9'd16;
      3'd1:    s = 9'd32;
      3'd2:    s = 9'd64;
      3'd3:    s = 9'd128;
      default: s = 9'd256;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/plg_if.sv
// Handshake channel interfaces of the pool level governor.
`default_nettype none

// Input item channel.
interface plg_item_if;
  logic               valid;
  logic               ready;
  plg_pkg::plg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result item channel.
interface plg_result_if;
  logic                 valid;
  logic                 ready;
  plg_pkg::plg_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Pool limit write channel.
interface plg_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/pool_level_governor.sv
// Top level of the pool level governor: input, state and result registers.
//
// The governor takes one item at a time on item_in_i (valid/ready) and
// returns exactly one result item per input item on result_o, in order.
// Op tick, while unlocked, places the rate in a band and advances the
// target/dwell logic; unless that rate missed every band, it reports alloc
// and free counts from the current level's watermarks. Op lock forces a
// level, op unlock releases it. The pool limit is written on cfg_i, which
// is always ready; write it only while no item is in flight.
// An accepted item waits in the input register; its result is written to
// the result register when the step advances.
// Throughput: one item per cycle while results are taken, set by the step
// logic that sits between the input register and the result register.
// When the receiver stalls, the result register holds its item; the input
// register can still take one more item, after which ready drops until the
// result is taken.
// Reset (rst_ni low) empties both registers, sets current and target level
// to 4, clears dwell and lock, and sets the pool limit to 1024.
`default_nettype none
module pool_level_governor (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  plg_item_if.sink       item_in_i,
  plg_result_if.source   result_o,
  plg_cfg_if.sink        cfg_i
);

  plg_pkg::plg_item_t   item_q;
  logic                 item_vld_q;
  plg_pkg::plg_result_t res_q;
  plg_pkg::plg_result_t res_d;
  logic                 res_vld_q;
  plg_pkg::plg_state_t  state_q;
  plg_pkg::plg_state_t  state_d;
  logic [15:0]          pool_limit_q;
  logic                 advance;
  logic                 in_acc;

  // Handshake control.
  assign advance         = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_in_i.ready = !item_vld_q || advance;
  assign in_acc          = item_in_i.valid && item_in_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign result_o.valid  = res_vld_q;
  assign result_o.payload = res_q;

  // Step logic.
  plg_step u_step (
    .item_i       (item_q),
    .state_i      (state_q),
    .pool_limit_i (pool_limit_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_acc) begin
      item_vld_q <= 1'b1;
    end else if (advance) begin
      item_vld_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_in_i.payload;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Governor state, updated as each item moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur    <= plg_pkg::LEVEL_RESET;
      state_q.tgt    <= plg_pkg::LEVEL_RESET;
      state_q.dwell  <= '0;
      state_q.locked <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Pool limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_limit_q <= plg_pkg::POOL_LIMIT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      pool_limit_q <= cfg_i.data;
    end
  end

  // The current level always stays within the band table.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cur < plg_pkg::LEVEL_COUNT)
    else $error("current level out of range");

  // A lock with an invalid level leaves the state untouched.
  a_bad_lock_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && plg_pkg::plg_op_e'(item_q.op) == plg_pkg::OP_LOCK &&
     item_q.lock_level >= plg_pkg::LEVEL_COUNT) |=> $stable(state_q))
    else $error("invalid lock changed the state");

  // A stalled result blocks the step so no item is lost.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !result_o.ready) |-> !advance)
    else $error("step advanced over a stalled result");

  // An unmatched tick reports the fixed sleep and no counts.
  a_miss_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.no_match) |->
    (res_q.sleep_seconds == plg_pkg::NO_MATCH_SLEEP && res_q.alloc_count == '0 &&
     res_q.free_count == '0))
    else $error("no-match result carries counts");

endmodule
`default_nettype wire

>>> sv/plg_step.sv
// Per-item logic: band match, level and dwell update, watermark counts.
`default_nettype none
module plg_step (
  input  var plg_pkg::plg_item_t   item_i,
  input  var plg_pkg::plg_state_t  state_i,
  input  var logic [15:0]          pool_limit_i,
  output var plg_pkg::plg_state_t  state_o,
  output var plg_pkg::plg_result_t result_o
);

  logic [plg_pkg::NUM_LEVELS-1:0] in_band;
  logic [plg_pkg::LEVEL_W-1:0]    hit;
  logic                           miss;
  logic [7:0]                     dwell_sum;
  plg_pkg::plg_state_t            tick_state;
  logic [plg_pkg::LEVEL_W-1:0]    lvl;
  logic [15:0]                    room;
  logic [8:0]                     alloc;
  logic [15:0]                    freec;
  logic [15:0]                    mark_hi;

  // Compare the rate against every band and keep the lowest match.
  always_comb begin
    hit = '0;
    for (int i = 0; i < plg_pkg::NUM_LEVELS; i++) begin
      in_band[i] = (item_i.rate >= plg_pkg::RATE_LOW[i]) &&
                   (item_i.rate <  plg_pkg::RATE_HIGH[i]);
    end
    for (int i = plg_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (in_band[i]) begin
        hit = plg_pkg::LEVEL_W'(i);
      end
    end
  end

  // Level step of an unlocked tick with a band match.
  always_comb begin
    tick_state = state_i;
    dwell_sum  = {1'b0, state_i.dwell} + {2'b00, plg_pkg::sample_time(state_i.cur)};
    if (hit == state_i.tgt) begin
      tick_state.dwell = (dwell_sum > {1'b0, plg_pkg::DWELL_MAX}) ?
                         plg_pkg::DWELL_MAX : dwell_sum[plg_pkg::DWELL_W-1:0];
    end else begin
      tick_state.tgt   = hit;
      tick_state.dwell = '0;
    end
    if (tick_state.dwell >= {1'b0, plg_pkg::valid_time(tick_state.tgt)}) begin
      if (tick_state.tgt != state_i.cur) begin
        tick_state.cur = tick_state.tgt;
      end else begin
        tick_state.dwell = '0;
      end
    end
  end

  // Next state per operation.
  always_comb begin
    state_o  = state_i;
    miss     = 1'b0;
    result_o = '0;
    unique case (plg_pkg::plg_op_e'(item_i.op))
      plg_pkg::OP_TICK: begin
        if (!state_i.locked) begin
          if (in_band == '0) begin
            miss = 1'b1;
          end else begin
            state_o = tick_state;
          end
        end
      end
      plg_pkg::OP_LOCK: begin
        if (item_i.lock_level < plg_pkg::LEVEL_COUNT) begin
          state_o.locked = 1'b1;
          state_o.cur    = item_i.lock_level;
        end else begin
          result_o.bad_level = 1'b1;
        end
      end
      plg_pkg::OP_UNLOCK: begin
        state_o.locked = 1'b0;
      end
      default: begin
      end
    endcase

    // Watermark counts use the level after the step.
    lvl     = state_o.cur;
    mark_hi = {6'd0, plg_pkg::mark_high(lvl)};
    room    = (pool_limit_i > item_i.total_count) ? pool_limit_i - item_i.total_count : '0;
    alloc   = '0;
    freec   = '0;
    if (item_i.idle_count <= {6'd0, plg_pkg::mark_low(lvl)}) begin
      alloc = ({7'd0, plg_pkg::inc_size(lvl)} < room) ? plg_pkg::inc_size(lvl) : room[8:0];
    end
    if (item_i.idle_count >= mark_hi) begin
      freec = item_i.idle_count - mark_hi;
    end

    // Only a tick that did not miss every band reports counts; a locked tick never misses.
    if (plg_pkg::plg_op_e'(item_i.op) == plg_pkg::OP_TICK && !miss) begin
      result_o.alloc_count = alloc;
      result_o.free_count  = freec;
    end
    result_o.no_match      = miss;
    result_o.sleep_seconds = miss ? plg_pkg::NO_MATCH_SLEEP : plg_pkg::sample_time(lvl);
    result_o.level         = state_o.cur;
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the pool level governor: random and directed items, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE_EDGES = 4;
  localparam int PHASE_ITEMS  = 270;
  localparam int DWELL_LIMIT  = 127;
  localparam int MISS_SLEEP   = 5;
  localparam int LEVELS       = plg_pkg::NUM_LEVELS;

  logic clk_i = 1'b0;
  logic rst_ni;

  plg_item_if   item_if ();
  plg_result_if result_if ();
  plg_cfg_if    cfg_if ();

  pool_level_governor dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_in_i (item_if),
    .result_o  (result_if),
    .cfg_i     (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Band table of the governor: rate range [lo, hi) and per-level settings.
  int          band_lo     [LEVELS] = '{-999, 2, 6, 10, 24};
  int          band_hi     [LEVELS] = '{2, 6, 10, 24, 999};
  int unsigned low_mark    [LEVELS] = '{64, 64, 64, 128, 128};
  int unsigned high_mark   [LEVELS] = '{128, 128, 128, 256, 512};
  int unsigned grow_step   [LEVELS] = '{16, 32, 64, 128, 256};
  int unsigned settle_time [LEVELS] = '{32, 16, 8, 4, 2};
  int unsigned tick_period [LEVELS] = '{32, 16, 8, 4, 1};

  // Mirrored governor state and pool limit.
  int          level_now  = 4;
  int          level_goal = 4;
  int          dwell_acc  = 0;
  bit          lock_held  = 1'b0;
  int unsigned limit_now  = 1024;

  plg_pkg::plg_item_t   items_to_send [$];
  plg_pkg::plg_result_t results_due [$];
  plg_pkg::plg_result_t due_now;
  int          fail_count = 0;
  bit          item_taken = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_granted = 0;
  int          hold_left = 0;

  // Advance the mirrored governor by one item and return the result it must give.
  function automatic plg_pkg::plg_result_t govern_step(plg_pkg::plg_item_t it);
    plg_pkg::plg_result_t r;
    int          rate;
    int          hit;
    int          dwell_sum;
    int unsigned room;
    bit          miss;
    r    = '0;
    miss = 1'b0;
    rate = int'($signed(it.rate));
    hit  = LEVELS;
    case (plg_pkg::plg_op_e'(it.op))
      plg_pkg::OP_TICK: begin
        if (!lock_held) begin
          for (int i = LEVELS - 1; i >= 0; i--) begin
            if (rate >= band_lo[i] && rate < band_hi[i]) hit = i;
          end
          if (hit == LEVELS) begin
            miss = 1'b1;
          end else begin
            if (hit == level_goal) begin
              dwell_sum = dwell_acc + int'(tick_period[level_now]);
              dwell_acc = (dwell_sum > DWELL_LIMIT) ? DWELL_LIMIT : dwell_sum;
            end else begin
              level_goal = hit;
              dwell_acc  = 0;
            end
            if (dwell_acc >= int'(settle_time[level_goal])) begin
              if (level_goal != level_now) level_now = level_goal;
              else dwell_acc = 0;
            end
          end
        end
        // Watermarks apply locked or not, unless the rate missed every band.
        if (!miss) begin
          if (it.idle_count <= low_mark[level_now]) begin
            room = (limit_now > it.total_count) ? limit_now - it.total_count : 0;
            r.alloc_count = 9'((room < grow_step[level_now]) ? room : grow_step[level_now]);
          end
          if (it.idle_count >= high_mark[level_now]) begin
            r.free_count = 16'(it.idle_count - high_mark[level_now]);
          end
        end
      end
      plg_pkg::OP_LOCK: begin
        if (it.lock_level < LEVELS) begin
          lock_held = 1'b1;
          level_now = it.lock_level;
        end else begin
          r.bad_level = 1'b1;
        end
      end
      plg_pkg::OP_UNLOCK: begin
        lock_held = 1'b0;
      end
      default: begin
      end
    endcase
    r.no_match      = miss;
    r.sleep_seconds = miss ? 6'(MISS_SLEEP) : 6'(tick_period[level_now]);
    r.level         = 3'(level_now);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic plg_pkg::plg_item_t make_item(plg_pkg::plg_op_e op, int rate,
                                                   int unsigned idle, int unsigned total,
                                                   int unsigned lvl);
    plg_pkg::plg_item_t it;
    it.op          = op;
    it.rate        = 16'(rate);
    it.idle_count  = 16'(idle);
    it.total_count = 16'(total);
    it.lock_level  = 3'(lvl);
    return it;
  endfunction

  function automatic int band_rate(int band);
    return band_lo[band] + int'($urandom_range(band_hi[band] - band_lo[band] - 1));
  endfunction

  // Idle counts cluster around the watermarks, with some spread over the full range.
  function automatic int unsigned pick_idle();
    int unsigned edges [12];
    int unsigned v;
    edges = '{63, 64, 65, 127, 128, 129, 255, 256, 257, 511, 512, 513};
    case ($urandom_range(3))
      0:       v = $urandom_range(140);
      1:       v = $urandom_range(600, 100);
      2:       v = $urandom_range(65535);
      default: v = edges[$urandom_range(11)];
    endcase
    return v;
  endfunction

  // Totals mostly near the pool limit so that the alloc cap comes into play.
  function automatic int unsigned pick_total();
    int t;
    case ($urandom_range(2))
      0:       t = int'($urandom_range(65535));
      1:       t = int'(limit_now) + 40 - int'($urandom_range(400));
      default: t = int'(limit_now);
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t;
  endfunction

  // Mostly runs of ticks in one band so that level changes go through; the rest is noise.
  task automatic queue_random(int count);
    int made;
    int sel;
    int band;
    int run;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(99);
      if (sel < 72) begin
        band = $urandom_range(LEVELS - 1);
        run  = $urandom_range(40, 1);
        repeat (run) begin
          items_to_send.push_back(make_item(plg_pkg::OP_TICK, band_rate(band), pick_idle(),
                                            pick_total(), $urandom_range(7)));
          made++;
        end
      end else if (sel < 78) begin
        items_to_send.push_back(make_item(plg_pkg::OP_LOCK, int'($urandom_range(65535)),
                                          pick_idle(), pick_total(), $urandom_range(7)));
        made++;
      end else if (sel < 88) begin
        items_to_send.push_back(make_item(plg_pkg::OP_UNLOCK, int'($urandom_range(65535)),
                                          pick_idle(), pick_total(), $urandom_range(7)));
        made++;
      end else if (sel < 92) begin
        items_to_send.push_back(make_item(plg_pkg::OP_RSVD, int'($urandom_range(65535)),
                                          $urandom_range(65535), $urandom_range(65535),
                                          $urandom_range(7)));
        made++;
      end else begin
        items_to_send.push_back(make_item(plg_pkg::OP_TICK,
                                          ($urandom_range(1) == 0) ?
                                            int'($urandom_range(65535)) :
                                            (($urandom_range(1) == 0) ? -1000 : 999),
                                          pick_idle(), pick_total(), $urandom_range(7)));
        made++;
      end
    end
  endtask

  // Wait until every queued item went in and every expected result came out.
  task automatic drain_all();
    while (items_to_send.size() != 0 || item_if.valid === 1'b1 || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_pool_limit(int unsigned value);
    drain_all();
    repeat (SETTLE_EDGES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= 16'(value);
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Input driver: offers the next queued item once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!item_if.valid || item_taken)) begin
      if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item_if.payload <= items_to_send.pop_front();
        item_if.valid   <= 1'b1;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus the long hold-off when one is running.
  always @(negedge clk_i) begin
    if (rst_ni) result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Counts down a requested hold-off of the receiver.
  always @(posedge clk_i) begin
    if (hold_asked != hold_granted) begin
      hold_granted <= hold_asked;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks results against the oldest expectation and predicts new items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      item_taken = (item_if.valid === 1'b1) && (item_if.ready === 1'b1);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        if (results_due.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fail_count++;
        end else begin
          due_now = results_due.pop_front();
          check_field("alloc_count", due_now.alloc_count, result_if.payload.alloc_count);
          check_field("free_count", due_now.free_count, result_if.payload.free_count);
          check_field("sleep_seconds", due_now.sleep_seconds,
                      result_if.payload.sleep_seconds);
          check_field("level", due_now.level, result_if.payload.level);
          check_field("no_match", due_now.no_match, result_if.payload.no_match);
          check_field("bad_level", due_now.bad_level, result_if.payload.bad_level);
        end
      end
      if (item_taken) results_due.push_back(govern_step(item_if.payload));
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) limit_now = cfg_if.data;
    end
  end

  initial begin : stimulus
    int unsigned limits    [5];
    int          send_pcts [5];
    int          stall_pcts[5];
    limits     = '{65535, 0, 200, $urandom_range(65535), 1024};
    send_pcts  = '{0, 53, 0, 21, 0};
    stall_pcts = '{0, 0, 53, 21, 0};
    rst_ni          = 1'b0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items: band edges, rates outside every band, field extremes, every op.
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 998, 0, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 24, 65535, 65535, 7));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, -1000, 0, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 999, 600, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, -32768, 0, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 32767, 65535, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, -999, 64, 1000, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 1, 65, 1024, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 2, 128, 1023, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 5, 129, 2000, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 6, 512, 10, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 9, 513, 10, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 10, 127, 900, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 23, 256, 900, 0));
    // Locked: level logic skipped even for a rate outside every band.
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 24, 64, 2000, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_TICK, 32767, 0, 0, 0));
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 5));
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 7));
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 4));
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 2));
    items_to_send.push_back(make_item(plg_pkg::OP_UNLOCK, -1, 65535, 65535, 7));
    items_to_send.push_back(make_item(plg_pkg::OP_RSVD, -1, 65535, 65535, 7));
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 1));
    items_to_send.push_back(make_item(plg_pkg::OP_LOCK, 0, 0, 0, 3));
    items_to_send.push_back(make_item(plg_pkg::OP_UNLOCK, 0, 0, 0, 0));
    drain_all();

    // Receiver holds off while the sender keeps offering, so the input stalls.
    @(negedge clk_i);
    hold_asked++;
    queue_random(30);
    drain_all();

    // Random phases, each with its own pool limit and idling mix.
    for (int p = 0; p < 5; p++) begin
      write_pool_limit(limits[p]);
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      queue_random(PHASE_ITEMS);
    end
    drain_all();
    repeat (SETTLE_EDGES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
